/* hw/rtl/fraction_alu_reduced_defines.svh */
// Assertion macros for the fraction ALU checker.
// Depends on nothing; included by the checker file.
`ifndef FRACTION_ALU_REDUCED_DEFINES_SVH
`define FRACTION_ALU_REDUCED_DEFINES_SVH
`define FAR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define FAR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

/* hw/rtl/fra_pkg.sv */
// Shared types and constants for the fraction ALU.
// Depends on nothing.
package fra_pkg;
    localparam int NumW = 32;
    localparam int DenW = 31;
    localparam int ProdW = 34;
    localparam int InW = 16;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_CHECK,
        ST_GSHIFT,
        ST_GODD,
        ST_GLOOP,
        ST_DIVN,
        ST_DIVD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic check;
        logic gshift;
        logic godd;
        logic gloop;
        logic div_start;
        logic div_step;
        logic div_sel_d;
        logic div_save;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic is_error;
        logic x_zero;
        logic y_zero;
        logic both_even;
        logic x_even;
        logic y_zero_loop;
        logic div_last;
    } stat_t;
endpackage

/* hw/rtl/fra_datapath.sv */
// Datapath: multiplies, binary gcd and serial exact division.
// Depends on fra_pkg.
module fra_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fra_pkg::cmd_t        cmd,
    output fra_pkg::stat_t       stat,
    input  logic [1:0]           op,
    input  logic [15:0]          a_num,
    input  logic [15:0]          a_den,
    input  logic [15:0]          b_num,
    input  logic [15:0]          b_den,
    output logic [31:0]          res_num,
    output logic [30:0]          res_den,
    output logic                 error
);
    import fra_pkg::*;

    logic [1:0]         op_reg;
    logic signed [15:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [31:0] p1_reg, p2_reg;
    logic signed [ProdW-1:0] n_reg, d_reg;
    logic               den_zero_reg;
    logic [ProdW-1:0]   x_reg, y_reg;
    logic [5:0]         k_reg;
    logic [ProdW-1:0]   g_reg;
    logic [ProdW-1:0]   rem_reg, quo_reg, dvd_reg;
    logic [5:0]         cnt_reg;
    logic [31:0]        qn_reg;
    logic               err_reg;

    logic signed [15:0] m1a, m1b, m2a, m2b;
    logic signed [31:0] m1, m2, m3;
    logic [ProdW-1:0]   n_mag, d_mag, x_sw, y_sw;
    logic [ProdW:0]     trial;
    logic [ProdW-1:0]   rem_sh;
    logic signed [ProdW-1:0] q_signed;

    always_comb
    begin
        unique case (op_reg)
            OP_MUL:
            begin
                m1a = an_reg; m1b = bn_reg; m2a = ad_reg; m2b = bd_reg;
            end
            OP_DIV:
            begin
                m1a = an_reg; m1b = bd_reg; m2a = ad_reg; m2b = bn_reg;
            end
            default:
            begin
                m1a = an_reg; m1b = bd_reg; m2a = bn_reg; m2b = ad_reg;
            end
        endcase
    end

    assign m1 = m1a * m1b;
    assign m2 = m2a * m2b;
    assign m3 = ad_reg * bd_reg;
    assign n_mag = n_reg[ProdW-1] ? ProdW'(-n_reg) : ProdW'(n_reg);
    assign d_mag = d_reg[ProdW-1] ? ProdW'(-d_reg) : ProdW'(d_reg);
    assign x_sw = (x_reg > y_reg) ? y_reg : x_reg;
    assign y_sw = (x_reg > y_reg) ? x_reg : y_reg;
    assign rem_sh = {rem_reg[ProdW-2:0], dvd_reg[ProdW-1]};
    assign trial = {1'b0, rem_sh} - {1'b0, g_reg};
    assign q_signed = (cmd.div_sel_d ? d_reg[ProdW-1] : n_reg[ProdW-1])
                      ? -$signed(quo_reg) : $signed(quo_reg);

    assign stat.is_error = den_zero_reg || (n_reg == '0 && d_reg == '0);
    assign stat.x_zero = (n_reg == '0);
    assign stat.y_zero = (d_reg == '0);
    assign stat.both_even = !x_reg[0] && !y_reg[0];
    assign stat.x_even = !x_reg[0];
    assign stat.y_zero_loop = (y_reg == '0);
    assign stat.div_last = (cnt_reg == 6'(ProdW - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg <= '0;
        end
        else if (cmd.load)
        begin
            op_reg <= op;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            an_reg <= a_num; ad_reg <= a_den; bn_reg <= b_num; bd_reg <= b_den;
            den_zero_reg <= (a_den == '0) || (b_den == '0);
        end
        if (cmd.mul1)
        begin
            p1_reg <= m1;
            p2_reg <= m2;
        end
        if (cmd.mul2)
        begin
            if (op_reg == OP_ADD)
                n_reg <= ProdW'(p1_reg) + ProdW'(p2_reg);
            else if (op_reg == OP_SUB)
                n_reg <= ProdW'(p1_reg) - ProdW'(p2_reg);
            else
                n_reg <= ProdW'(p1_reg);
            if (op_reg == OP_MUL || op_reg == OP_DIV)
                d_reg <= ProdW'(p2_reg);
            else
                d_reg <= ProdW'(m3);
        end
        if (cmd.check)
        begin
            x_reg <= n_mag;
            y_reg <= d_mag;
            k_reg <= '0;
            if (n_reg == '0)
                g_reg <= d_mag;
            else if (d_reg == '0)
                g_reg <= n_mag;
        end
        if (cmd.gshift)
        begin
            x_reg <= x_reg >> 1;
            y_reg <= y_reg >> 1;
            k_reg <= k_reg + 6'd1;
        end
        if (cmd.godd)
            x_reg <= x_reg >> 1;
        if (cmd.gloop)
        begin
            if (!y_reg[0])
                y_reg <= y_reg >> 1;
            else
            begin
                x_reg <= x_sw;
                y_reg <= y_sw - x_sw;
            end
        end
        if (cmd.div_start)
        begin
            if (!stat.x_zero && !stat.y_zero && !cmd.div_sel_d)
                g_reg <= x_reg << k_reg;
            dvd_reg <= cmd.div_sel_d ? d_mag : n_mag;
            rem_reg <= '0;
            quo_reg <= '0;
            cnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            dvd_reg <= dvd_reg << 1;
            cnt_reg <= cnt_reg + 6'd1;
            if (!trial[ProdW])
            begin
                rem_reg <= trial[ProdW-1:0];
                quo_reg <= {quo_reg[ProdW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[ProdW-2:0], 1'b0};
            end
        end
        if (cmd.div_save)
            qn_reg <= n_reg[ProdW-1] ? 32'(-$signed(quo_reg)) : quo_reg[31:0];
        if (cmd.finish)
        begin
            err_reg <= stat.is_error;
            if (stat.is_error)
            begin
                res_num <= '0;
                res_den <= '0;
            end
            else
            begin
                res_num <= qn_reg;
                res_den <= q_signed[30:0];
            end
        end
    end

    assign error = err_reg;
endmodule

/* hw/rtl/fra_ctrl.sv */
// Controller state machine sequencing the fraction datapath.
// Depends on fra_pkg.
module fra_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_req,
    output logic            in_ack,
    output logic            out_valid,
    input  logic            out_ack,
    output fra_pkg::cmd_t   cmd,
    input  fra_pkg::stat_t  stat
);
    import fra_pkg::*;

    state_t state_reg, state_next;
    logic   sel_d_reg, sel_d_next;
    logic   valid_reg, valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_d_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_d_reg <= sel_d_next;
            valid_reg <= valid_next;
        end
    end

    assign in_ack = (state_reg == ST_IDLE);
    assign out_valid = valid_reg;

    always_comb
    begin
        state_next = state_reg;
        sel_d_next = sel_d_reg;
        valid_next = valid_reg && !out_ack;
        cmd = '0;
        cmd.div_sel_d = sel_d_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_req)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                cmd.mul1 = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2 = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.check = 1'b1;
                sel_d_next = 1'b0;
                if (stat.is_error)
                    state_next = ST_DONE;
                else if (stat.x_zero || stat.y_zero)
                    state_next = ST_DIVN;
                else
                    state_next = ST_GSHIFT;
            end
            ST_GSHIFT:
            begin
                if (stat.both_even)
                    cmd.gshift = 1'b1;
                else
                    state_next = ST_GODD;
            end
            ST_GODD:
            begin
                if (stat.x_even)
                    cmd.godd = 1'b1;
                else
                    state_next = ST_GLOOP;
            end
            ST_GLOOP:
            begin
                if (!stat.y_zero_loop)
                    cmd.gloop = 1'b1;
                else
                    state_next = ST_DIVN;
            end
            ST_DIVN:
            begin
                cmd.div_start = 1'b1;
                state_next = ST_DIVD;
            end
            ST_DIVD:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    if (!sel_d_reg)
                    begin
                        sel_d_next = 1'b1;
                        state_next = ST_DIVN;
                    end
                    else
                        state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!valid_reg || out_ack)
                begin
                    cmd.finish = 1'b1;
                    valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (state_reg == ST_DIVN && sel_d_reg)
            cmd.div_save = 1'b1;
    end
endmodule

/* hw/rtl/fraction_alu_reduced.sv */
// Top level of the fraction ALU with gcd reduction.
// Depends on fra_pkg, fra_ctrl and fra_datapath.
//  channel | dir | tdata fields (low first)            | tuser
//  s_axis  | in  | a_num, a_den, b_num, b_den         | op
//  m_axis  | out | res_num, res_den, pad 1            | error
// One request at a time: multiply and check, then binary gcd steps, then two
// serial divisions, numerator first; error requests skip the gcd and the
// divisions. The binary gcd loop sets the variable part of the run time.
// The result register holds while m_axis_tready is low; a new request is
// taken during that wait. rst_n clears control state asynchronously.
module fraction_alu_reduced (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // a_num, a_den, b_num, b_den
    input  logic [1:0]  s_axis_tuser,  // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // res_num, res_den, zero pad
    output logic        m_axis_tuser   // error
);
    import fra_pkg::*;

    cmd_t        cmd;
    stat_t       stat;
    logic [31:0] res_num;
    logic [30:0] res_den;

    fra_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_req(s_axis_tvalid), .in_ack(s_axis_tready),
        .out_valid(m_axis_tvalid), .out_ack(m_axis_tready),
        .cmd(cmd), .stat(stat)
    );

    fra_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .op(s_axis_tuser),
        .a_num(s_axis_tdata[15:0]), .a_den(s_axis_tdata[31:16]),
        .b_num(s_axis_tdata[47:32]), .b_den(s_axis_tdata[63:48]),
        .res_num(res_num), .res_den(res_den), .error(m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, res_den, res_num};
endmodule

/* hw/rtl/fra_checker.sv */
// Port checker for the fraction ALU, bound to the top level.
// Depends on fraction_alu_reduced_defines.svh.
`include "fraction_alu_reduced_defines.svh"
module fra_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    `FAR_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped")
    `FAR_ASSERT_IMPL(a_err_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 64'd0, "error result not zero")
    `FAR_ASSERT_NEXT(a_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second request taken")
    `FAR_ASSERT_IMPL(a_pad, m_axis_tvalid, !m_axis_tdata[63], "pad bit set")
endmodule

bind fraction_alu_reduced fra_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
